// File: rtl/tsts_pkg.sv
// Package: shared types and codes of the timer slot table scheduler.
package tsts_pkg;

    localparam int TIME_W   = 64;
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    localparam logic [1:0] KIND_FREE     = 2'd0;
    localparam logic [1:0] KIND_ONESHOT  = 2'd1;
    localparam logic [1:0] KIND_PERIODIC = 2'd2;

    localparam logic [OP_W-1:0] OP_ONESHOT_ABS = 3'd0;
    localparam logic [OP_W-1:0] OP_ONESHOT_REL = 3'd1;
    localparam logic [OP_W-1:0] OP_PERIODIC    = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE        = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK        = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ACT  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] period;
    } slot_ent_t;

endpackage

// File: rtl/timer_slot_table_scheduler_unit.sv
// Top level: timer slot table scheduler built on a rotating ring of slot cells.
//
// Usage: drive op, now, time_value and slot_index with start high while busy
// is low; that edge accepts the transaction. The slots sit in a ring of cells
// that rotates one place per cycle while an op is scanned; the controller works
// on the slot at the head, so one op needs one full turn of the ring.
// Non-tick ops: after the turn, one result with last high appears.
// Tick op: after the turn, fired slots are reported in slot order during a
// second pass over the slots (one result per fired slot), then the summary
// result with last high. A new transaction may start the cycle busy drops.
// Each result is valid for one cycle, marked by result_valid; the receiver
// cannot stall, so no results are held back.
// Reset marks every slot free and returns the controller to idle; deadline
// and period storage is not cleared, since a slot is written on allocation.
module timer_slot_table_scheduler_unit
    import tsts_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic [TIME_W-1:0]   now,
    input  logic [TIME_W-1:0]   time_value,
    input  logic [SLOT_W-1:0]   slot_index,
    output logic                result_valid,
    output logic [SLOT_W-1:0]   slot,
    output logic                fired,
    output logic [STATUS_W-1:0] status,
    output logic [TIME_W-1:0]   next_deadline,
    output logic                deadline_valid,
    output logic                last
);

    localparam int PW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PW-1:0] CNT_LAST = PW'(SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_DONE} state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    tv_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic [PW-1:0]        cnt_reg;
    logic                 found_reg, found_next;
    logic [SLOT_W-1:0]    rslot_reg, rslot_next;
    logic [STATUS_W-1:0]  rstat_reg, rstat_next;
    logic [TIME_W-1:0]    min_reg, min_next;
    logic                 any_reg, any_next;
    logic [SLOTS-1:0]     mask_reg, mask_next;

    logic                 valid_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 fired_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 last_reg;

    slot_ent_t            ring [SLOTS];
    slot_ent_t            head, head_next;
    logic                 shift;
    logic                 head_act, next_act;

    // ring: each cell takes its right neighbor; the processed head goes to the tail
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            slot_ent_t cin;
            if (g == SLOTS - 1)
            begin : g_tail
                assign cin = head_next;
            end
            else
            begin : g_mid
                assign cin = ring[g+1];
            end
            tsts_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .ent_in  (cin),
                .ent_out (ring[g])
            );
        end
    endgenerate

    assign head  = ring[0];
    assign shift = (state_reg == S_SCAN);
    assign head_act = (head.kind == KIND_ONESHOT) || (head.kind == KIND_PERIODIC);

    always_comb
    begin
        head_next  = head;
        found_next = found_reg;
        rslot_next = rslot_reg;
        rstat_next = rstat_reg;
        mask_next  = mask_reg;
        case (op_reg)
            OP_ONESHOT_ABS, OP_ONESHOT_REL, OP_PERIODIC:
            begin
                if (!found_reg && !head_act)
                begin
                    found_next = 1'b1;
                    rslot_next = SLOT_W'(cnt_reg);
                    rstat_next = ST_OK;
                    if (op_reg == OP_PERIODIC)
                    begin
                        head_next.kind   = KIND_PERIODIC;
                        head_next.period = tv_reg;
                    end
                    else
                    begin
                        head_next.kind = KIND_ONESHOT;
                    end
                    head_next.deadline = (op_reg == OP_ONESHOT_ABS) ? tv_reg
                                                                    : now_reg + tv_reg;
                end
            end
            OP_FREE:
            begin
                if ((32'(idx_reg) == 32'(cnt_reg)) && head_act)
                begin
                    head_next.kind = KIND_FREE;
                    rstat_next     = ST_OK;
                end
            end
            OP_TICK:
            begin
                if (head_act && (head.deadline <= now_reg))
                begin
                    mask_next[cnt_reg[IW-1:0]] = 1'b1;
                    if (head.kind == KIND_ONESHOT)
                    begin
                        head_next.kind = KIND_FREE;
                    end
                    else
                    begin
                        head_next.deadline = head.deadline + head.period;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign next_act = (head_next.kind == KIND_ONESHOT) || (head_next.kind == KIND_PERIODIC);

    always_comb
    begin
        min_next = min_reg;
        any_next = any_reg;
        if (next_act)
        begin
            if (!any_reg || (head_next.deadline < min_reg))
            begin
                min_next = head_next.deadline;
            end
            any_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            valid_reg  <= 1'b0;
            found_reg  <= 1'b0;
            any_reg    <= 1'b0;
            mask_reg   <= '0;
            slot_reg   <= '0;
            fired_reg  <= 1'b0;
            status_reg <= ST_OK;
            last_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        any_reg   <= 1'b0;
                        mask_reg  <= '0;
                    end
                end
                S_SCAN:
                begin
                    found_reg <= found_next;
                    any_reg   <= any_next;
                    mask_reg  <= mask_next;
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (op_reg == OP_TICK) ? S_EMIT : S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    valid_reg  <= mask_reg[cnt_reg[IW-1:0]];
                    slot_reg   <= SLOT_W'(cnt_reg);
                    fired_reg  <= 1'b1;
                    status_reg <= ST_OK;
                    last_reg   <= 1'b0;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    valid_reg  <= 1'b1;
                    slot_reg   <= rslot_reg;
                    fired_reg  <= 1'b0;
                    status_reg <= rstat_reg;
                    last_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // transaction payload and per-op result fields
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= op;
            now_reg <= now;
            tv_reg  <= time_value;
            idx_reg <= slot_index;
            if (op == OP_FREE)
            begin
                rslot_reg <= slot_index;
                rstat_reg <= ST_NOT_ACT;
            end
            else
            begin
                rslot_reg <= '0;
                rstat_reg <= (op <= OP_PERIODIC) ? ST_FULL : ST_OK;
            end
        end
        else if (state_reg == S_SCAN)
        begin
            rslot_reg <= rslot_next;
            rstat_reg <= rstat_next;
            min_reg   <= min_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = valid_reg;
    assign slot           = slot_reg;
    assign fired          = fired_reg;
    assign status         = status_reg;
    assign last           = last_reg;
    assign deadline_valid = any_reg;
    assign next_deadline  = any_reg ? min_reg : '0;

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fired |-> !last)
        else $error("fired result marked last");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final result while still busy");

    a_fired_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fired |-> op_reg == OP_TICK)
        else $error("fired result outside a tick");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> cnt_reg <= CNT_LAST)
        else $error("slot counter out of range");

endmodule

// File: rtl/tsts_cell.sv
// One slot cell of the rotating slot ring.
module tsts_cell
    import tsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  slot_ent_t ent_in,
    output slot_ent_t ent_out
);

    logic [1:0]        kind_reg;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_FREE;
        end
        else if (shift)
        begin
            kind_reg <= ent_in.kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            deadline_reg <= ent_in.deadline;
            period_reg   <= ent_in.period;
        end
    end

    assign ent_out.kind     = kind_reg;
    assign ent_out.deadline = deadline_reg;
    assign ent_out.period   = period_reg;

endmodule

// File: tb/timer_slot_table_scheduler_unit_tb.sv
// Testbench for the timer slot table scheduler: directed and random op streams checked against a predictor.
`timescale 1ns / 100ps

module timer_slot_table_scheduler_unit_tb;
    import tsts_pkg::*;

    localparam int NSLOT = 16;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] tv;
        logic [SLOT_W-1:0] idx;
    } timer_cmd_t;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic                fired;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   next_dl;
        logic                dl_valid;
        logic                last;
    } timer_rsp_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     op;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   time_value;
    logic [SLOT_W-1:0]   slot_index;
    logic                result_valid;
    logic [SLOT_W-1:0]   slot;
    logic                fired;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   next_deadline;
    logic                deadline_valid;
    logic                last;

    timer_slot_table_scheduler_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .now(now),
        .time_value(time_value), .slot_index(slot_index), .result_valid(result_valid),
        .slot(slot), .fired(fired), .status(status), .next_deadline(next_deadline),
        .deadline_valid(deadline_valid), .last(last)
    );

    // shadow slot table
    logic [1:0]        kind_sh [NSLOT];
    logic [TIME_W-1:0] dl_sh   [NSLOT];
    logic [TIME_W-1:0] per_sh  [NSLOT];

    timer_cmd_t pending_cmds[$];
    timer_rsp_t expected_rsps[$];
    int         errors;
    int         gap_pct;
    int         n_fired;
    int         n_full;
    int         n_items;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit slot_active(int i);
        return kind_sh[i] == KIND_ONESHOT || kind_sh[i] == KIND_PERIODIC;
    endfunction

    // apply one op to the shadow table and queue what it should produce
    function automatic void predict_timer_op(timer_cmd_t c);
        timer_rsp_t rs[$];
        timer_rsp_t r;
        int         s;
        logic [TIME_W-1:0] mn;
        bit         any;
        s = -1;
        any = 1'b0;
        mn = '0;
        r = '{default: '0};
        r.last = 1'b1;
        if (c.op == OP_ONESHOT_ABS || c.op == OP_ONESHOT_REL || c.op == OP_PERIODIC)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (s < 0 && !slot_active(i)) s = i;
            if (s < 0)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                r.slot = s[SLOT_W-1:0];
                if (c.op == OP_ONESHOT_ABS)
                begin
                    kind_sh[s] = KIND_ONESHOT;
                    dl_sh[s] = c.tv;
                end
                else if (c.op == OP_ONESHOT_REL)
                begin
                    kind_sh[s] = KIND_ONESHOT;
                    dl_sh[s] = c.now + c.tv;
                end
                else
                begin
                    kind_sh[s] = KIND_PERIODIC;
                    dl_sh[s] = c.now + c.tv;
                    per_sh[s] = c.tv;
                end
            end
            rs.push_back(r);
        end
        else if (c.op == OP_FREE)
        begin
            r.slot = c.idx;
            if (slot_active(c.idx))
                kind_sh[c.idx] = KIND_FREE;
            else
                r.status = ST_NOT_ACT;
            rs.push_back(r);
        end
        else if (c.op == OP_TICK)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (slot_active(i) && dl_sh[i] <= c.now)
                begin
                    timer_rsp_t f;
                    f = '{default: '0};
                    if (kind_sh[i] == KIND_ONESHOT)
                        kind_sh[i] = KIND_FREE;
                    else
                        dl_sh[i] = dl_sh[i] + per_sh[i];
                    f.slot = i[SLOT_W-1:0];
                    f.fired = 1'b1;
                    rs.push_back(f);
                    n_fired++;
                end
            end
            rs.push_back(r);
        end
        else
            rs.push_back(r);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_active(i))
            begin
                if (!any || dl_sh[i] < mn) mn = dl_sh[i];
                any = 1'b1;
            end
        end
        foreach (rs[k])
        begin
            rs[k].next_dl = any ? mn : '0;
            rs[k].dl_valid = any;
            expected_rsps.push_back(rs[k]);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic timer_cmd_t make_cmd(logic [OP_W-1:0] o, logic [63:0] t_now,
                                            logic [63:0] t_val, logic [3:0] ix);
        timer_cmd_t c;
        c.op = o;
        c.now = t_now;
        c.tv = t_val;
        c.idx = ix;
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= '0;
            now <= '0;
            time_value <= '0;
            slot_index <= '0;
        end
        else if (!(start && busy))
        begin
            // previous transaction (if any) accepted at this edge
            if (start) predict_timer_op('{op, now, time_value, slot_index});
            if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                timer_cmd_t c;
                c = pending_cmds.pop_front();
                start <= 1'b1;
                op <= c.op;
                now <= c.now;
                time_value <= c.tv;
                slot_index <= c.idx;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result slot=%0d fired=%0b last=%0b",
                         $time, slot, fired, last);
                errors++;
            end
            else
            begin
                timer_rsp_t e;
                e = expected_rsps.pop_front();
                if (slot !== e.slot || fired !== e.fired || status !== e.status ||
                    next_deadline !== e.next_dl || deadline_valid !== e.dl_valid ||
                    last !== e.last)
                begin
                    $display("%0t: mismatch expected slot=%0d fired=%0b st=%0d nd=%h dv=%0b last=%0b",
                             $time, e.slot, e.fired, e.status, e.next_dl, e.dl_valid, e.last);
                    $display("%0t:          actual slot=%0d fired=%0b st=%0d nd=%h dv=%0b last=%0b",
                             $time, slot, fired, status, next_deadline, deadline_valid, last);
                    errors++;
                end
            end
        end
    end

    task automatic drain_phase();
        while (pending_cmds.size() != 0 || start || busy || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] t;
        logic [2:0]  o;
        errors = 0;
        n_fired = 0;
        n_full = 0;
        n_items = 0;
        gap_pct = 22;
        for (int i = 0; i < NSLOT; i++)
        begin
            kind_sh[i] = KIND_FREE;
            dl_sh[i] = '0;
            per_sh[i] = '0;
        end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, wrap, zero period, table full, bad frees, unknown ops
        pending_cmds.push_back(make_cmd(OP_FREE, 0, 0, 4'd0));
        pending_cmds.push_back(make_cmd(OP_TICK, '1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ONESHOT_ABS, 0, '1, 4'hf));
        pending_cmds.push_back(make_cmd(OP_ONESHOT_ABS, '1, 0, 0));
        pending_cmds.push_back(make_cmd(OP_ONESHOT_REL, '1, 64'd5, 0));
        pending_cmds.push_back(make_cmd(OP_PERIODIC, 64'd100, 0, 0));
        pending_cmds.push_back(make_cmd(OP_PERIODIC, '1, '1, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, 64'd100, 0, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, 64'd200, 0, 0));
        for (int i = 0; i < 12; i++)
            pending_cmds.push_back(make_cmd(OP_PERIODIC, 64'd1000, 64'd50 + i, 4'(i)));
        pending_cmds.push_back(make_cmd(OP_ONESHOT_REL, 0, 1, 0));
        pending_cmds.push_back(make_cmd(OP_FREE, 0, 0, 4'd15));
        pending_cmds.push_back(make_cmd(3'd5, '1, '1, 4'hf));
        pending_cmds.push_back(make_cmd(3'd7, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_TICK, '1, 0, 0));
        n_items = pending_cmds.size();
        drain_phase();

        // random: a moving time base, mixed allocations, frees and ticks
        t = 64'd10000;
        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 22 : (ph == 1) ? 80 : 0;
            for (int n = 0; n < 35; n++)
            begin
                t = t + $urandom_range(400);
                case ($urandom_range(9))
                    0: o = OP_ONESHOT_ABS;
                    1, 2: o = OP_ONESHOT_REL;
                    3: o = OP_PERIODIC;
                    4, 5: o = OP_FREE;
                    9: o = 3'($urandom_range(7));
                    default: o = OP_TICK;
                endcase
                if ($urandom_range(19) == 0)
                    pending_cmds.push_back(make_cmd(o, rand64(), rand64(), 4'($urandom())));
                else
                    pending_cmds.push_back(make_cmd(o, t,
                        ($urandom_range(9) == 0) ? 64'd0 : 64'($urandom_range(1500)),
                        4'($urandom())));
            end
            n_items += 35;
            drain_phase();
        end
        repeat (50) @(posedge clk);
        $display("Ran %0d ops across three idle profiles: %0d slot expiries, %0d full-table hits.",
                 n_items, n_fired, n_full);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
